@@ rtl/tcfo_pkg.sv @@
// Shared types and constants for the two-class oldest-first FIFO unit.
package tcfo_pkg;

    localparam int TAG_W       = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    // Two extra bits keep the signed stamp distance exact for up to 2*QUEUE_DEPTH entries.
    localparam int STAMP_W     = PTR_W + 2;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ_ANY = 2'd1,
        OP_DEQ_A   = 2'd2,
        OP_DEQ_B   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic CLASS_A = 1'b0;
    localparam logic CLASS_B = 1'b1;

    typedef struct packed {
        op_t               opcode;
        logic              item_class;
        logic [TAG_W-1:0]  payload_in;
    } cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]  payload_out;
        logic              served_class;
        status_t           status;
        logic [CNT_W-1:0]  count_a;
        logic [CNT_W-1:0]  count_b;
    } res_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_next;
        entry_t           head;
    } q_stat_t;

endpackage

@@ rtl/tcfo_queue.sv @@
// One class queue: entry memory, read pointer and fill count, registered head entry.
module tcfo_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  tcfo_pkg::q_ctrl_t ctrl,
    input  tcfo_pkg::entry_t  wr_entry,
    output tcfo_pkg::q_stat_t stat
);
    import tcfo_pkg::*;

    entry_t           mem [QUEUE_DEPTH];
    entry_t           head_entry_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [PTR_W-1:0] tail;

    assign tail      = head_reg + fill_reg[PTR_W-1:0];
    assign head_next = ctrl.pop ? head_reg + PTR_W'(1) : head_reg;
    assign fill_next = fill_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // The read port always looks at the next head, so the head entry register
    // is ready along with the new head pointer; a write to that same slot is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= wr_entry;
        end
        if (ctrl.push && (tail == head_next))
        begin
            head_entry_reg <= wr_entry;
        end
        else
        begin
            head_entry_reg <= mem[head_next];
        end
    end

    assign stat.count      = fill_reg;
    assign stat.count_next = fill_next;
    assign stat.head       = head_entry_reg;

endmodule

@@ rtl/two_class_fifo_oldest_first_unit.sv @@
// Top level of the two-class FIFO unit with oldest-first dequeue.
//
// Usage: a command beat (enqueue, dequeue-any, dequeue A, dequeue B) is
// taken on cmd at a rising edge with start high and busy low. busy is held
// low, so a new command may be issued in every cycle.
// Each command produces exactly one result beat on result, marked by done
// for a single cycle. The receiver cannot hold results off; it must take
// the beat in the cycle that done is high.
// The command is captured in the command register; the decision logic then
// sets the result register and done. Throughput is one command per cycle,
// set by the single decision stage that reads both registered head entries
// and updates the pointers and the shared arrival stamp at the same edge.
// Enqueueing stamps the item with a shared wrapping counter; dequeue-any
// serves the head with the older stamp, class A on a tie. A full queue
// drops the item and reports it; an empty queue reports an empty status.
// Reset empties both queues and clears the stamp; the entry memories are
// not cleared, as only written entries are ever read.
module two_class_fifo_oldest_first_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tcfo_pkg::cmd_t cmd,
    output logic           done,
    output tcfo_pkg::res_t result
);
    import tcfo_pkg::*;

    cmd_t               cmd_reg;
    logic               cmd_valid_reg;
    res_t               result_reg;
    res_t               result_next;
    logic               done_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;

    q_ctrl_t ctrl_a;
    q_ctrl_t ctrl_b;
    q_stat_t stat_a;
    q_stat_t stat_b;
    entry_t  wr_entry;

    logic               has_a;
    logic               has_b;
    logic               full_a;
    logic               full_b;
    logic [STAMP_W-1:0] stamp_diff;
    logic               a_older;
    status_t            status_next;

    // The command register isolates the caller from the decision logic.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
    end

    tcfo_queue u_queue_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_a),
        .wr_entry (wr_entry),
        .stat     (stat_a)
    );

    tcfo_queue u_queue_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_b),
        .wr_entry (wr_entry),
        .stat     (stat_b)
    );

    assign has_a  = (stat_a.count != '0);
    assign has_b  = (stat_b.count != '0);
    assign full_a = (stat_a.count == CNT_W'(QUEUE_DEPTH));
    assign full_b = (stat_b.count == CNT_W'(QUEUE_DEPTH));

    // Age is compared modulo the stamp width: A is older, or tied, when the
    // wrapped difference is zero or negative.
    assign stamp_diff = stat_a.head.stamp - stat_b.head.stamp;
    assign a_older    = (stamp_diff == '0) || stamp_diff[STAMP_W-1];

    assign wr_entry.tag   = cmd_reg.payload_in;
    assign wr_entry.stamp = stamp_reg;

    // Decide which queue is pushed or popped for the command in the register.
    always_comb
    begin
        ctrl_a      = '0;
        ctrl_b      = '0;
        status_next = ST_OK;
        if (cmd_valid_reg)
        begin
            unique case (cmd_reg.opcode)
                OP_ENQ:
                begin
                    if (cmd_reg.item_class == CLASS_B)
                    begin
                        if (full_b)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl_b.push = 1'b1;
                        end
                    end
                    else
                    begin
                        if (full_a)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl_a.push = 1'b1;
                        end
                    end
                end
                OP_DEQ_ANY:
                begin
                    priority if (has_a && has_b)
                    begin
                        ctrl_a.pop = a_older;
                        ctrl_b.pop = !a_older;
                    end
                    else if (has_a)
                    begin
                        ctrl_a.pop = 1'b1;
                    end
                    else if (has_b)
                    begin
                        ctrl_b.pop = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                OP_DEQ_A:
                begin
                    if (has_a)
                    begin
                        ctrl_a.pop = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                OP_DEQ_B:
                begin
                    if (has_b)
                    begin
                        ctrl_b.pop = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // The stamp moves on only when an item is actually stored.
    assign stamp_next = (ctrl_a.push || ctrl_b.push) ? stamp_reg + STAMP_W'(1) : stamp_reg;

    always_comb
    begin
        result_next.payload_out  = '0;
        result_next.served_class = CLASS_A;
        if (ctrl_a.pop)
        begin
            result_next.payload_out = stat_a.head.tag;
        end
        else if (ctrl_b.pop)
        begin
            result_next.payload_out  = stat_b.head.tag;
            result_next.served_class = CLASS_B;
        end
        result_next.status  = status_next;
        result_next.count_a = stat_a.count_next;
        result_next.count_b = stat_b.count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            stamp_reg <= '0;
        end
        else
        begin
            done_reg  <= cmd_valid_reg;
            stamp_reg <= stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted command produces its result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted command produced no result beat");

    // A command that reports class B as served always carries an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.served_class) |-> (result.status == ST_OK))
        else $error("class B reported as served on a failed command");

    // A failed dequeue returns no payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_EMPTY)) |-> (result.payload_out == '0))
        else $error("payload returned on an empty dequeue");

    // Occupancy never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.count_a <= CNT_W'(QUEUE_DEPTH))
                  && (result.count_b <= CNT_W'(QUEUE_DEPTH))))
        else $error("queue occupancy beyond depth");

    // The stamp changes only after a stored enqueue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stamp_reg != $past(stamp_reg)) |-> $past(ctrl_a.push || ctrl_b.push))
        else $error("arrival stamp advanced without an enqueue");

endmodule
